[hw/rtl/lru_pkg.sv]
package lru_pkg;

  // fixed widths of the item fields and the capacity register
  localparam int PAGE_IN_W = 16;
  localparam int CAP_W     = 4;
  localparam int COUNT_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // control passed from one cell to the next, most recent end first
  typedef struct packed {
    logic valid;     // the sending cell holds a page
    logic hit_seen;  // a hit was found in some cell before this one
    logic ev_valid;  // an earlier cell is trimmed this item
  } lru_fwd_t;

endpackage

[hw/rtl/lru_cell.sv]
module lru_cell #(
  parameter int IDX       = 0,
  parameter int PAGE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [PAGE_BITS-1:0]         pg,
  input  logic [lru_pkg::CAP_W-1:0]    cap_eff,
  input  logic                         no_trim,
  input  lru_pkg::lru_fwd_t            fwd_in,
  input  logic [PAGE_BITS-1:0]         prev_page,
  input  logic [PAGE_BITS-1:0]         ev_page_in,
  input  logic                         nxt_v_in,
  output lru_pkg::lru_fwd_t            fwd_out,
  output logic [PAGE_BITS-1:0]         page_out,
  output logic [PAGE_BITS-1:0]         ev_page_out,
  output logic                         v_shift_out
);
  import lru_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 match, shift, v_shift, over_cap, trim;

  // compare against the referenced page
  assign match = valid_r && (page_r == pg);

  // cells up to and including the hit take their neighbour's entry
  assign shift    = !fwd_in.hit_seen;
  assign v_shift  = shift ? fwd_in.valid : valid_r;
  assign page_nxt = shift ? prev_page : page_r;

  // drop this entry if it is the last one and lies beyond the capacity
  assign over_cap  = IDX >= int'(cap_eff);
  assign trim      = v_shift && !nxt_v_in && over_cap && !no_trim;
  assign valid_nxt = v_shift && !trim;

  // hand-off to the next cell
  assign fwd_out.valid    = valid_r;
  assign fwd_out.hit_seen = fwd_in.hit_seen || match;
  assign fwd_out.ev_valid = fwd_in.ev_valid || trim;
  assign ev_page_out      = ev_page_in | (trim ? page_nxt : '0);
  assign page_out         = page_r;
  assign v_shift_out      = v_shift;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  // page held
  always_ff @(posedge clk) begin
    if (en) begin
      page_r <= page_nxt;
    end
  end

endmodule

[hw/rtl/lru_page_replacement.sv]
// LRU page replacement table, fully associative.
// Input channel: in_valid / in_stall with in_page, one page reference per item.
// Result channel: out_valid / out_stall with out_fault, out_evicted_valid,
// out_evicted_page and out_fault_count, exactly one result per input item.
// Configuration: cfg_we / cfg_data writes the capacity (0 acts as 1, values
// above MAX_ENTRIES act as MAX_ENTRIES); write it only while the block is idle.
// The table is a row of MAX_ENTRIES cells kept in recency order: the first
// cell holds the most recent page. A reference is compared in every cell at
// once and the cells up to the hit shift by one.
// The result is registered and shown the cycle after the item is accepted.
// Throughput: one item per cycle while out_stall is low.
// While the receiver stalls a waiting result, in_stall is raised and the
// table holds; the result stays on the ports unchanged until taken.
// Reset (rst_n low, synchronous) empties the table, clears the fault total
// and sets the capacity to 8. No clearing pass is needed.
module lru_page_replacement #(
  parameter int MAX_ENTRIES = 8,
  parameter int PAGE_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lru_pkg::PAGE_IN_W-1:0]  in_page,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_fault,
  output logic                           out_evicted_valid,
  output logic [lru_pkg::PAGE_IN_W-1:0]  out_evicted_page,
  output logic [lru_pkg::COUNT_W-1:0]    out_fault_count,
  input  logic                           cfg_we,
  input  logic [lru_pkg::CAP_W-1:0]      cfg_data
);
  import lru_pkg::*;

  logic                   in_accept;
  logic [PAGE_BITS-1:0]   pg;
  logic [CAP_W-1:0]       capacity_r;
  logic [CAP_W-1:0]       cap_eff;
  logic                   miss, full_ev;
  logic                   ev_valid;
  logic [PAGE_BITS-1:0]   ev_page;
  logic [PAGE_IN_W-1:0]   ev_page_out;
  logic [COUNT_W-1:0]     total_r, total_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   fault_r, evv_r;
  logic [PAGE_IN_W-1:0]   evp_r;
  logic [MAX_ENTRIES-1:0] valid_vec;

  lru_fwd_t               fwd      [MAX_ENTRIES+1];
  logic [PAGE_BITS-1:0]   page_row [MAX_ENTRIES];
  logic [PAGE_BITS-1:0]   ev_chain [MAX_ENTRIES+1];
  logic                   v_shift  [MAX_ENTRIES+1];

  // handshake: the single result register parts the two sides
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // page number reduced to the table width, evicted page back to the port width
  generate
    if (PAGE_BITS >= PAGE_IN_W) begin : g_wide
      assign pg          = PAGE_BITS'(in_page);
      assign ev_page_out = ev_page[PAGE_IN_W-1:0];
    end else begin : g_narrow
      assign pg          = in_page[PAGE_BITS-1:0];
      assign ev_page_out = PAGE_IN_W'(ev_page);
    end
  endgenerate

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_data;
    end
  end

  // effective capacity, clamped to one .. MAX_ENTRIES
  always_comb begin
    if (capacity_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (int'(capacity_r) > MAX_ENTRIES) begin
      cap_eff = CAP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = capacity_r;
    end
  end

  // head of the chain: the new page enters the first cell
  assign fwd[0].valid    = 1'b1;
  assign fwd[0].hit_seen = 1'b0;
  assign fwd[0].ev_valid = 1'b0;
  assign ev_chain[0]     = '0;
  assign v_shift[MAX_ENTRIES] = 1'b0;

  // row of cells
  generate
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_first
        lru_cell #(.IDX(i), .PAGE_BITS(PAGE_BITS)) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .en         (in_accept),
          .pg         (pg),
          .cap_eff    (cap_eff),
          .no_trim    (full_ev),
          .fwd_in     (fwd[i]),
          .prev_page  (pg),
          .ev_page_in (ev_chain[i]),
          .nxt_v_in   (v_shift[i+1]),
          .fwd_out    (fwd[i+1]),
          .page_out   (page_row[i]),
          .ev_page_out(ev_chain[i+1]),
          .v_shift_out(v_shift[i])
        );
      end else begin : g_rest
        lru_cell #(.IDX(i), .PAGE_BITS(PAGE_BITS)) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .en         (in_accept),
          .pg         (pg),
          .cap_eff    (cap_eff),
          .no_trim    (full_ev),
          .fwd_in     (fwd[i]),
          .prev_page  (page_row[i-1]),
          .ev_page_in (ev_chain[i]),
          .nxt_v_in   (v_shift[i+1]),
          .fwd_out    (fwd[i+1]),
          .page_out   (page_row[i]),
          .ev_page_out(ev_chain[i+1]),
          .v_shift_out(v_shift[i])
        );
      end
      assign valid_vec[i] = fwd[i+1].valid;
    end
  endgenerate

  // miss on a full table pushes the oldest page out of the last cell
  assign miss     = !fwd[MAX_ENTRIES].hit_seen;
  assign full_ev  = miss && valid_vec[MAX_ENTRIES-1];
  assign ev_valid = full_ev || fwd[MAX_ENTRIES].ev_valid;
  assign ev_page  = full_ev ? page_row[MAX_ENTRIES-1] : ev_chain[MAX_ENTRIES];

  // saturating fault total
  always_comb begin
    total_nxt = total_r;
    if (miss && (total_r != '1)) begin
      total_nxt = total_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (in_accept) begin
      total_r <= total_nxt;
    end
  end

  // result register
  assign out_valid_nxt = in_accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fault_r <= miss;
      evv_r   <= ev_valid;
      evp_r   <= ev_valid ? ev_page_out : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fault         = fault_r;
  assign out_evicted_valid = evv_r;
  assign out_evicted_page  = evp_r;
  assign out_fault_count   = total_r;

`ifndef SYNTHESIS
  // occupied cells always form an unbroken run from the most recent end
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, valid_vec} + (MAX_ENTRIES+1)'(1)))
    else $error("occupied cells not contiguous");

  // no evicted page shown without its flag
  a_ev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !evv_r |-> evp_r == '0)
    else $error("evicted page set without eviction");

  // a fault result always carries a total that moved or is saturated
  a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && miss |=> (total_r == $past(total_r) + COUNT_W'(1)) || (total_r == '1))
    else $error("fault total not advanced on a miss");

  // a hit leaves the total alone
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !miss |=> $stable(total_r))
    else $error("fault total changed on a hit");
`endif

endmodule
